// File: rtl/hpr_pkg.sv
`default_nettype none

package hpr_pkg;

    localparam int unsigned CFG_W         = 17;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64 * 1024);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [7:0] {
        PH_METHOD    = 8'b0000_0001,
        PH_PATH      = 8'b0000_0010,
        PH_VERSION   = 8'b0000_0100,
        PH_VERSION_LF = 8'b0000_1000,
        PH_NAME      = 8'b0001_0000,
        PH_VALUE     = 8'b0010_0000,
        PH_HEADER_LF = 8'b0100_0000,
        PH_END_LF    = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        CL_NONE    = 3'd0,
        CL_METHOD  = 3'd1,
        CL_PATH    = 3'd2,
        CL_VERSION = 3'd3,
        CL_NAME    = 3'd4,
        CL_VALUE   = 3'd5
    } t_field_class;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_FIELD_END   = 3'd1,
        EV_HEAD_DONE   = 3'd2,
        EV_CLEAN_CLOSE = 3'd3,
        EV_MALFORMED   = 3'd4,
        EV_TOO_LARGE   = 3'd5,
        EV_TRUNCATED   = 3'd6
    } t_event;

    typedef struct packed {
        logic [7:0]   byte_out;
        t_field_class field_class;
        logic         is_blank;
        t_event       event_res;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/hpr_in_if.sv
`default_nettype none

interface hpr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/hpr_out_if.sv
`default_nettype none

interface hpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] field_class;
    logic       is_blank;
    logic [2:0] event_res;

    modport source (
        output valid, output byte_out, output field_class, output is_blank,
        output event_res, input ready
    );
    modport sink (
        input valid, input byte_out, input field_class, input is_blank,
        input event_res, output ready
    );
endinterface

`default_nettype wire

// File: rtl/http_request_head_parser.sv
`default_nettype none

// Channel   Dir   Handshake      Payload
// i_req     in    valid/ready    command[0], data_byte[7:0]
// o_res     out   valid/ready    byte_out[7:0], field_class[2:0], is_blank, event_res[2:0]
// cfg       in    i_cfg_wr_en    i_cfg_wr_data[16:0] (max_head_bytes)
//
// One item per cycle while i_req.ready is high; each result is registered before it appears.
// The parse state updates in the accept cycle and the result goes into a
// registered output stage backed by a one-entry skid register.
// i_req.ready drops only while the skid register holds a stalled item.
// Synchronous active-low reset clears the parse state and sets the limit to 65536.

module http_request_head_parser
    import hpr_pkg::*;
#(
    parameter int unsigned HEAD_LIMIT_MAX = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    hpr_in_if.sink                i_req,
    hpr_out_if.source             o_res
);

    logic [CFG_W-1:0] r_max_head_bytes;
    logic             accept;
    logic             in_ready;
    t_result          result;
    t_result          out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_head_bytes <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_head_bytes <= i_cfg_wr_data;
        end
    end

    assign i_req.ready = in_ready;
    assign accept      = i_req.valid && in_ready;

    hpr_parse_core #(
        .HEAD_LIMIT_MAX (HEAD_LIMIT_MAX)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_command        (i_req.command),
        .i_data_byte      (i_req.data_byte),
        .i_max_head_bytes (r_max_head_bytes),
        .o_result         (result)
    );

    hpr_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_item      (result),
        .o_ready     (in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_item  (out_item)
    );

    assign o_res.byte_out    = out_item.byte_out;
    assign o_res.field_class = 3'(out_item.field_class);
    assign o_res.is_blank    = out_item.is_blank;
    assign o_res.event_res   = 3'(out_item.event_res);

endmodule

`default_nettype wire

// File: rtl/hpr_parse_core.sv
`default_nettype none

module hpr_parse_core
    import hpr_pkg::*;
#(
    parameter int unsigned HEAD_LIMIT_MAX = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [CFG_W-1:0] i_max_head_bytes,
    output t_result               o_result
);

    localparam int unsigned CW = $clog2(HEAD_LIMIT_MAX + 1);
    localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count;
    logic          r_line_bytes, n_line_bytes;
    logic          r_skip_blanks, n_skip_blanks;
    logic          r_error, n_error;

    logic [LW-1:0] cfg_ext;
    logic [LW-1:0] limit;
    logic          blank;

    assign cfg_ext = LW'(i_max_head_bytes);
    assign limit   = (cfg_ext > LW'(HEAD_LIMIT_MAX)) ? LW'(HEAD_LIMIT_MAX) : cfg_ext;
    assign blank   = (i_data_byte == CH_SP) || (i_data_byte == CH_TAB);

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_line_bytes  = r_line_bytes;
        n_skip_blanks = r_skip_blanks;
        n_error       = r_error;

        o_result.byte_out    = i_data_byte;
        o_result.field_class = CL_NONE;
        o_result.is_blank    = blank;
        o_result.event_res   = EV_NONE;

        if (i_command) begin
            // end of input: report and return to the idle state
            o_result.byte_out = 8'd0;
            o_result.is_blank = 1'b0;
            if (r_error || (r_phase == PH_METHOD && r_count == '0)) begin
                o_result.event_res = EV_CLEAN_CLOSE;
            end else begin
                o_result.event_res = EV_TRUNCATED;
            end
            n_phase       = PH_METHOD;
            n_count       = '0;
            n_line_bytes  = 1'b0;
            n_skip_blanks = 1'b0;
            n_error       = 1'b0;
        end else if (r_error) begin
            // pass bytes untagged until the input ends
        end else if (LW'(r_count) >= limit) begin
            o_result.event_res = EV_TOO_LARGE;
            n_error            = 1'b1;
        end else begin
            n_count = r_count + CW'(1);
            case (r_phase)
                PH_METHOD: begin
                    if (i_data_byte == CH_SP) begin
                        o_result.event_res = EV_FIELD_END;
                        n_phase            = PH_PATH;
                    end else begin
                        o_result.field_class = CL_METHOD;
                    end
                end
                PH_PATH: begin
                    if (i_data_byte == CH_SP) begin
                        o_result.event_res = EV_FIELD_END;
                        n_phase            = PH_VERSION;
                    end else begin
                        o_result.field_class = CL_PATH;
                    end
                end
                PH_VERSION: begin
                    if (i_data_byte == CH_CR) begin
                        o_result.event_res = EV_FIELD_END;
                        n_phase            = PH_VERSION_LF;
                    end else begin
                        o_result.field_class = CL_VERSION;
                    end
                end
                PH_VERSION_LF, PH_HEADER_LF: begin
                    if (i_data_byte == CH_LF) begin
                        n_phase       = PH_NAME;
                        n_line_bytes  = 1'b0;
                        n_skip_blanks = 1'b0;
                    end else begin
                        o_result.event_res = EV_MALFORMED;
                        n_error            = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (i_data_byte == CH_CR) begin
                        // empty line ends the head; a name without colon is bad
                        if (!r_line_bytes) begin
                            n_phase = PH_END_LF;
                        end else begin
                            o_result.event_res = EV_MALFORMED;
                            n_error            = 1'b1;
                        end
                    end else if (i_data_byte == CH_COLON) begin
                        n_skip_blanks      = 1'b1;
                        o_result.event_res = EV_FIELD_END;
                        n_phase            = PH_VALUE;
                    end else begin
                        n_line_bytes         = 1'b1;
                        o_result.field_class = CL_NAME;
                    end
                end
                PH_VALUE: begin
                    if (i_data_byte == CH_CR) begin
                        o_result.event_res = EV_FIELD_END;
                        n_phase            = PH_HEADER_LF;
                    end else if (r_skip_blanks && blank) begin
                        o_result.field_class = CL_NONE;
                    end else begin
                        n_skip_blanks        = 1'b0;
                        o_result.field_class = CL_VALUE;
                    end
                end
                PH_END_LF: begin
                    if (i_data_byte == CH_LF) begin
                        o_result.event_res = EV_HEAD_DONE;
                        n_phase            = PH_METHOD;
                        n_count            = '0;
                        n_line_bytes       = 1'b0;
                        n_skip_blanks      = 1'b0;
                        n_error            = 1'b0;
                    end else begin
                        o_result.event_res = EV_MALFORMED;
                        n_error            = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_METHOD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_METHOD;
            r_count       <= '0;
            r_line_bytes  <= 1'b0;
            r_skip_blanks <= 1'b0;
            r_error       <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_line_bytes  <= n_line_bytes;
            r_skip_blanks <= n_skip_blanks;
            r_error       <= n_error;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hpr_out_skid.sv
`default_nettype none

module hpr_out_skid
    import hpr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_item,
    output logic         o_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_result      o_out_item
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    accept;
    logic    out_free;

    assign o_ready     = !r_skid_valid;
    assign accept      = i_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            // output stalled: park the item
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_item;
        end else if (accept) begin
            r_skid <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: dv/http_request_head_parser_tb.sv
`default_nettype none

module http_request_head_parser_tb
    import hpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAD_LIMIT_MAX = 65536;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned DRAIN_CYCLES   = 3;
    localparam int unsigned REPORT_MAX     = 10;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_in_byte;

    typedef enum int {
        FLAW_NONE,
        FLAW_NO_COLON,
        FLAW_BAD_CRLF,
        FLAW_CUT,
        FLAW_GARBLE
    } t_head_flaw;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    hpr_in_if  req_if ();
    hpr_out_if res_if ();

    http_request_head_parser #(
        .HEAD_LIMIT_MAX(HEAD_LIMIT_MAX)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_req        (req_if),
        .o_res        (res_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Parser model state
    logic [CFG_W-1:0] head_limit;
    t_phase           ph;
    int unsigned      hd_count;
    logic             line_nonempty;
    logic             strip_blanks;
    logic             err_latched;

    t_in_byte    pend_q[$];
    t_result     exp_results_q[$];
    logic [7:0]  hb[$];

    int unsigned pushed_total;
    int unsigned accepted_total;
    int unsigned result_total;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    int unsigned hold_seq;
    int unsigned hold_seen;
    int unsigned hold_left;
    logic        req_taken;

    function automatic void clear_parse();
        ph            = PH_METHOD;
        hd_count      = 0;
        line_nonempty = 1'b0;
        strip_blanks  = 1'b0;
        err_latched   = 1'b0;
    endfunction

    function automatic t_result parse_byte(input logic cmd, input logic [7:0] b);
        t_result     r;
        int unsigned lim;
        r.byte_out    = b;
        r.field_class = CL_NONE;
        r.is_blank    = (b == CH_SP) || (b == CH_TAB);
        r.event_res   = EV_NONE;
        if (cmd) begin
            r.byte_out  = 8'h00;
            r.is_blank  = 1'b0;
            r.event_res = (err_latched || (ph == PH_METHOD && hd_count == 0)) ?
                          EV_CLEAN_CLOSE : EV_TRUNCATED;
            clear_parse();
            return r;
        end
        lim = (head_limit > HEAD_LIMIT_MAX) ? HEAD_LIMIT_MAX : head_limit;
        if (err_latched) begin
            // pass untagged until the stream ends
        end else if (hd_count >= lim) begin
            r.event_res = EV_TOO_LARGE;
            err_latched = 1'b1;
        end else begin
            hd_count++;
            case (ph)
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        r.event_res = EV_FIELD_END;
                        ph = PH_PATH;
                    end else begin
                        r.field_class = CL_METHOD;
                    end
                end
                PH_PATH: begin
                    if (b == CH_SP) begin
                        r.event_res = EV_FIELD_END;
                        ph = PH_VERSION;
                    end else begin
                        r.field_class = CL_PATH;
                    end
                end
                PH_VERSION: begin
                    if (b == CH_CR) begin
                        r.event_res = EV_FIELD_END;
                        ph = PH_VERSION_LF;
                    end else begin
                        r.field_class = CL_VERSION;
                    end
                end
                PH_VERSION_LF, PH_HEADER_LF: begin
                    if (b == CH_LF) begin
                        ph            = PH_NAME;
                        line_nonempty = 1'b0;
                        strip_blanks  = 1'b0;
                    end else begin
                        r.event_res = EV_MALFORMED;
                        err_latched = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (b == CH_CR) begin
                        if (!line_nonempty) begin
                            ph = PH_END_LF;
                        end else begin
                            r.event_res = EV_MALFORMED;
                            err_latched = 1'b1;
                        end
                    end else if (b == CH_COLON) begin
                        strip_blanks = 1'b1;
                        r.event_res  = EV_FIELD_END;
                        ph           = PH_VALUE;
                    end else begin
                        line_nonempty = 1'b1;
                        r.field_class = CL_NAME;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_CR) begin
                        r.event_res = EV_FIELD_END;
                        ph = PH_HEADER_LF;
                    end else if (strip_blanks && r.is_blank) begin
                        r.field_class = CL_NONE;
                    end else begin
                        strip_blanks  = 1'b0;
                        r.field_class = CL_VALUE;
                    end
                end
                PH_END_LF: begin
                    if (b == CH_LF) begin
                        r.event_res = EV_HEAD_DONE;
                        clear_parse();
                    end else begin
                        r.event_res = EV_MALFORMED;
                        err_latched = 1'b1;
                    end
                end
                default: begin
                    ph = PH_METHOD;
                end
            endcase
        end
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    // Sender: hold the offered item until taken, then advance
    always @(negedge clk) begin
        if (req_if.valid && req_taken) begin
            pend_q.delete(0);
        end
        if (req_if.valid && !req_taken) begin
            // hold
        end else if (pend_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
            req_if.valid     <= 1'b1;
            req_if.command   <= pend_q[0].cmd;
            req_if.data_byte <= pend_q[0].data;
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus a long hold when requested
    always @(negedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Check results first so a byte taken at this edge never matches itself
    always @(posedge clk) begin : monitor
        t_result want;
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                result_total <= result_total + 1;
                if (exp_results_q.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           result_total));
                end else begin
                    want = exp_results_q.pop_front();
                    if (res_if.byte_out !== want.byte_out ||
                        res_if.field_class !== want.field_class ||
                        res_if.is_blank !== want.is_blank ||
                        res_if.event_res !== want.event_res) begin
                        note_failure($sformatf({"result %0d: expected byte %02h class %0d ",
                            "blank %0b event %0d, got byte %02h class %0d blank %0b event %0d"},
                            result_total, want.byte_out, want.field_class, want.is_blank,
                            want.event_res, res_if.byte_out, res_if.field_class,
                            res_if.is_blank, res_if.event_res));
                    end
                end
            end
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                accepted_total <= accepted_total + 1;
                exp_results_q.insert(exp_results_q.size(),
                                     parse_byte(req_if.command, req_if.data_byte));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pend_q.insert(pend_q.size(), t_in_byte'{1'b0, b});
        pushed_total++;
    endtask

    task automatic push_end();
        pend_q.insert(pend_q.size(), t_in_byte'{1'b1, 8'($urandom_range(0, 255))});
        pushed_total++;
    endtask

    function automatic void head_add(input logic [7:0] c);
        hb.insert(hb.size(), c);
    endfunction

    function automatic logic [7:0] field_byte(input logic [7:0] stop_a,
                                              input logic [7:0] stop_b);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 4) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = 8'($urandom_range(8'h21, 8'h7E));
            end
        end while (c == stop_a || c == stop_b);
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? CH_SP : CH_TAB;
    endfunction

    task automatic build_head(input t_head_flaw flaw);
        int         n_hdr;
        int         bad_line;
        int         pos;
        logic [7:0] c;
        hb.delete();
        repeat ($urandom_range(0, 5)) head_add(field_byte(CH_SP, CH_SP));
        head_add(CH_SP);
        repeat ($urandom_range(0, 6)) head_add(field_byte(CH_SP, CH_SP));
        head_add(CH_SP);
        repeat ($urandom_range(0, 6)) head_add(field_byte(CH_CR, CH_CR));
        head_add(CH_CR);
        head_add(CH_LF);
        n_hdr    = $urandom_range((flaw == FLAW_NO_COLON) ? 1 : 0, 3);
        bad_line = (flaw == FLAW_NO_COLON) ? $urandom_range(0, n_hdr - 1) : -1;
        for (int h = 0; h < n_hdr; h++) begin
            // a line without a colon needs a name byte to be malformed
            repeat ($urandom_range((h == bad_line) ? 1 : 0, 6)) begin
                head_add(field_byte(CH_CR, CH_COLON));
            end
            if (h != bad_line) begin
                head_add(CH_COLON);
                repeat ($urandom_range(0, 2)) head_add(blank_byte());
                repeat ($urandom_range(0, 6)) head_add(field_byte(CH_CR, CH_CR));
                repeat ($urandom_range(0, 1)) head_add(blank_byte());
            end
            head_add(CH_CR);
            head_add(CH_LF);
        end
        head_add(CH_CR);
        head_add(CH_LF);
        if (flaw == FLAW_BAD_CRLF) begin
            do pos = $urandom_range(0, hb.size() - 2); while (hb[pos] != CH_CR);
            do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
            hb[pos + 1] = c;
        end else if (flaw == FLAW_GARBLE) begin
            hb[$urandom_range(0, hb.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic send_head(input t_head_flaw flaw);
        int n;
        build_head(flaw);
        n = (flaw == FLAW_CUT) ? $urandom_range(1, hb.size() - 1) : hb.size();
        for (int i = 0; i < n; i++) push_byte(hb[i]);
        if (flaw == FLAW_CUT) push_end();
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned target;
        int unsigned r;
        target = pushed_total + n_items;
        while (pushed_total < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_head(FLAW_NONE);
                if ($urandom_range(0, 3) == 0) push_end();
            end else if (r < 85) begin
                send_head(t_head_flaw'($urandom_range(FLAW_NO_COLON, FLAW_GARBLE)));
                if ($urandom_range(0, 9) < 7) push_end();
            end else if (r < 95) begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_end();
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (accepted_total != pushed_total || result_total != accepted_total);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit, input int unsigned snd_idle,
                             input int unsigned rcv_idle, input int unsigned n_items);
        wait_drained();
        @(negedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= limit;
        head_limit   = limit;
        in_idle_pct  = snd_idle;
        out_idle_pct = rcv_idle;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        random_traffic(n_items);
    endtask

    initial begin : stimulus
        logic [7:0]  full_head[$];
        logic [7:0]  no_colon[$];
        int unsigned start;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_if.valid     = 1'b0;
        req_if.command   = 1'b0;
        req_if.data_byte = 8'h00;
        res_if.ready     = 1'b0;
        pushed_total     = 0;
        accepted_total   = 0;
        result_total     = 0;
        fail_cnt         = 0;
        cycle_cnt        = 0;
        hold_seq         = 0;
        hold_seen        = 0;
        hold_left        = 0;
        req_taken        = 1'b0;
        in_idle_pct      = 14;
        out_idle_pct     = 65;
        head_limit       = CFG_RESET;
        clear_parse();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extreme bytes, LF inside the version, blanks dropped at the start of a value
        full_head = '{8'h00, CH_SP, 8'hFF, CH_SP, CH_LF, CH_CR, CH_LF, 8'h78, CH_COLON,
                      CH_SP, CH_TAB, 8'h76, CH_SP, CH_CR, CH_LF, CH_CR, CH_LF};
        // Empty request line fields, then a header line with no colon
        no_colon = '{CH_SP, CH_SP, CH_CR, CH_LF, 8'h6B, CH_CR, 8'h7A};
        push_end();
        foreach (full_head[i]) push_byte(full_head[i]);
        foreach (no_colon[i]) push_byte(no_colon[i]);
        push_end();

        start = pushed_total;
        random_traffic(300);
        // stall the output while the sender keeps offering
        while (accepted_total < start + 20) @(posedge clk);
        hold_seq = hold_seq + 1;

        run_phase(17'd1, 14, 65, 60);
        run_phase(17'd40, 65, 14, 300);
        run_phase(CFG_RESET, 65, 14, 250);
        run_phase(17'h1FFFF, 0, 0, 250);
        run_phase(17'd0, 0, 0, 40);
        run_phase(17'd200, 0, 0, 50);
        wait_drained();

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/hpr_pkg.sv
rtl/hpr_in_if.sv
rtl/hpr_out_if.sv
rtl/hpr_parse_core.sv
rtl/hpr_out_skid.sv
rtl/http_request_head_parser.sv
dv/http_request_head_parser_tb.sv
